// ===== src/seu_pkg.sv =====
package seu_pkg;

  // Endpointer modes as reported on the result channel.
  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_SPEAKING   = 2'd1,
    MODE_FINALIZING = 2'd2
  } mode_t;

  // Intents emitted with each result.
  typedef enum logic [1:0] {
    INTENT_NONE  = 2'd0,
    INTENT_BEGIN = 2'd1,
    INTENT_END   = 2'd2
  } intent_t;

  // Event codes on the input channel.
  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_END    = 3'd1,
    OP_TICK   = 3'd2,
    OP_FORCE  = 3'd3,
    OP_DONE   = 3'd4,
    OP_ABORT  = 3'd5
  } opcode_t;

  localparam int OP_BITS  = 3;
  localparam int CAP_BITS = 32;
  localparam int SEQ_BITS = 32;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 32'd480000;

  // Control part of one result, passed from the update logic to the result register.
  typedef struct packed {
    intent_t intent;
    logic    reopened;
    mode_t   mode;
  } res_ctrl_t;

endpackage

// ===== src/seu_if.sv =====
// Event channel into the endpointer.
interface seu_in_if #(
  parameter int STAMP_BITS = 48
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            opcode;
  logic [STAMP_BITS-1:0] sample_stamp;

  modport source (output valid, opcode, sample_stamp, input ready);
  modport sink   (input valid, opcode, sample_stamp, output ready);
endinterface

// Result channel out of the endpointer.
interface seu_out_if #(
  parameter int STAMP_BITS = 48
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            intent;
  logic                  reopened;
  logic [1:0]            mode;
  logic [31:0]           utterance_seq;
  logic [STAMP_BITS-1:0] utterance_start;
  logic [STAMP_BITS-1:0] utterance_end;

  modport source (output valid, intent, reopened, mode, utterance_seq, utterance_start,
                  utterance_end, input ready);
  modport sink   (input valid, intent, reopened, mode, utterance_seq, utterance_start,
                  utterance_end, output ready);
endinterface

// ===== src/seu_ctrl.sv =====
module seu_ctrl #(
  parameter int STAMP_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ev_valid,
  input  logic [seu_pkg::OP_BITS-1:0]   ev_opcode,
  input  logic [STAMP_BITS-1:0]         ev_stamp,
  input  logic [seu_pkg::CAP_BITS-1:0]  cap,
  output seu_pkg::res_ctrl_t            ctrl,
  output logic [seu_pkg::SEQ_BITS-1:0]  seq_nxt,
  output logic [STAMP_BITS-1:0]         start_nxt,
  output logic [STAMP_BITS-1:0]         end_nxt
);
  import seu_pkg::*;

  localparam int LEN_BITS = (STAMP_BITS > CAP_BITS) ? STAMP_BITS : CAP_BITS;

  mode_t                 mode_r, mode_nxt;
  logic                  barge_r, barge_nxt;
  logic [STAMP_BITS-1:0] start_r;
  logic [STAMP_BITS-1:0] pend_r, pend_nxt;
  logic [STAMP_BITS-1:0] end_r;
  logic [SEQ_BITS-1:0]   seq_r;
  logic [STAMP_BITS-1:0] len;
  logic                  stamp_ge;
  logic                  cap_hit;

  // Utterance length against the cap; a stamp before the start counts as zero length.
  assign stamp_ge = (ev_stamp >= start_r);
  assign len      = ev_stamp - start_r;
  assign cap_hit  = stamp_ge ? (LEN_BITS'(len) >= LEN_BITS'(cap)) : (cap == '0);

  // State registers, updated once per processed event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      barge_r <= 1'b0;
      start_r <= '0;
      pend_r  <= '0;
      end_r   <= '0;
      seq_r   <= '0;
    end else if (ev_valid) begin
      mode_r  <= mode_nxt;
      barge_r <= barge_nxt;
      start_r <= start_nxt;
      pend_r  <= pend_nxt;
      end_r   <= end_nxt;
      seq_r   <= seq_nxt;
    end
  end

  // Event decode: next mode, stamps and the intent of this event.
  always_comb begin
    mode_nxt      = mode_r;
    barge_nxt     = barge_r;
    start_nxt     = start_r;
    pend_nxt      = pend_r;
    end_nxt       = end_r;
    seq_nxt       = seq_r;
    ctrl.intent   = INTENT_NONE;
    ctrl.reopened = 1'b0;
    case (opcode_t'(ev_opcode))
      OP_START: begin
        if (mode_r == MODE_IDLE) begin
          mode_nxt    = MODE_SPEAKING;
          start_nxt   = ev_stamp;
          seq_nxt     = seq_r + 1'b1;
          ctrl.intent = INTENT_BEGIN;
        end else if (mode_r == MODE_FINALIZING) begin
          barge_nxt = 1'b1;
          pend_nxt  = ev_stamp;
        end
      end
      OP_END: begin
        if (mode_r == MODE_SPEAKING) begin
          mode_nxt    = MODE_FINALIZING;
          end_nxt     = ev_stamp;
          ctrl.intent = INTENT_END;
        end else if (mode_r == MODE_FINALIZING) begin
          barge_nxt = 1'b0;
        end
      end
      OP_TICK: begin
        if (mode_r == MODE_SPEAKING && cap_hit) begin
          mode_nxt    = MODE_FINALIZING;
          end_nxt     = ev_stamp;
          ctrl.intent = INTENT_END;
        end
      end
      OP_FORCE: begin
        if (mode_r == MODE_SPEAKING) begin
          mode_nxt    = MODE_FINALIZING;
          end_nxt     = ev_stamp;
          ctrl.intent = INTENT_END;
        end
      end
      OP_DONE: begin
        if (barge_r) begin
          barge_nxt     = 1'b0;
          mode_nxt      = MODE_SPEAKING;
          start_nxt     = pend_r;
          seq_nxt       = seq_r + 1'b1;
          ctrl.intent   = INTENT_BEGIN;
          ctrl.reopened = 1'b1;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      OP_ABORT: begin
        mode_nxt  = MODE_IDLE;
        barge_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    ctrl.mode = mode_nxt;
  end

`ifndef NO_ASSERTIONS
  // A reopen always comes with a begin intent.
  a_reopen_begins: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid && ctrl.reopened |-> ctrl.intent == INTENT_BEGIN)
    else $error("reopen without begin intent");

  // Every begin intent counts exactly one utterance.
  a_begin_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid && ctrl.intent == INTENT_BEGIN |=> seq_r == $past(seq_r) + 1'b1)
    else $error("begin intent did not advance the sequence count");

  // A barge-in is only ever held while finalizing.
  a_barge_finalizing: assert property (@(posedge clk) disable iff (!rst_n)
    barge_r |-> mode_r == MODE_FINALIZING)
    else $error("barge-in pending outside finalizing");

  // Without a processed event the mode does not move.
  a_mode_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ev_valid |=> $stable(mode_r))
    else $error("mode changed without an event");
`endif
endmodule

// ===== src/speech_utterance_endpointer_core.sv =====
// Speech utterance endpointer.
// Events (opcode and sample stamp) arrive on in_ch as valid/ready transfers; each
// event produces exactly one result on out_ch: intent, reopened flag, mode after the
// event, utterance count and the current start and end stamps.
// cfg_we with cfg_wdata writes the utterance length cap; write it only while no event
// is in flight.
// The input register captures an event at its transfer and the result register takes it
// when it is free or emptying; out_ch.valid comes from the result register. Throughput:
// one event per cycle while out_ch.ready stays high, with one subtract and compare for
// the length cap in the update of the mode registers.
// in_ch.ready stays high while the input register is empty or moving forward, so
// the block takes a new event while the previous result waits on out_ch.
// When the receiver stalls, the result holds, the input register fills and then
// in_ch.ready drops until out_ch.ready returns.
// Reset (rst_n low, synchronous) empties both registers, returns to idle with no
// pending barge-in, clears stamps and count and restores the cap to 480000.
module speech_utterance_endpointer_core #(
  parameter int STAMP_BITS = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  seu_in_if.sink                        in_ch,
  seu_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [seu_pkg::CAP_BITS-1:0]  cfg_wdata
);
  import seu_pkg::*;

  logic [CAP_BITS-1:0]   cap_r;
  logic                  s1_valid_r;
  logic [OP_BITS-1:0]    s1_op_r;
  logic [STAMP_BITS-1:0] s1_stamp_r;
  logic                  s1_advance;
  logic                  res_valid_r;
  res_ctrl_t             res_ctrl_r;
  logic [SEQ_BITS-1:0]   res_seq_r;
  logic [STAMP_BITS-1:0] res_start_r;
  logic [STAMP_BITS-1:0] res_end_r;
  res_ctrl_t             ctrl;
  logic [SEQ_BITS-1:0]   seq_nxt;
  logic [STAMP_BITS-1:0] start_nxt;
  logic [STAMP_BITS-1:0] end_nxt;

  // Handshake: the input stage moves on when the result register is free or emptying.
  assign s1_advance  = s1_valid_r && (!res_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_advance;

  // Length cap register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r    <= in_ch.opcode;
      s1_stamp_r <= in_ch.sample_stamp;
    end
  end

  // Mode tracking and event decode.
  seu_ctrl #(
    .STAMP_BITS (STAMP_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (s1_advance),
    .ev_opcode (s1_op_r),
    .ev_stamp  (s1_stamp_r),
    .cap       (cap_r),
    .ctrl      (ctrl),
    .seq_nxt   (seq_nxt),
    .start_nxt (start_nxt),
    .end_nxt   (end_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (s1_advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_ctrl_r  <= ctrl;
      res_seq_r   <= seq_nxt;
      res_start_r <= start_nxt;
      res_end_r   <= end_nxt;
    end
  end

  assign out_ch.valid           = res_valid_r;
  assign out_ch.intent          = res_ctrl_r.intent;
  assign out_ch.reopened        = res_ctrl_r.reopened;
  assign out_ch.mode            = res_ctrl_r.mode;
  assign out_ch.utterance_seq   = res_seq_r;
  assign out_ch.utterance_start = res_start_r;
  assign out_ch.utterance_end   = res_end_r;
endmodule

// ===== dv/speech_utterance_endpointer_core_tb.sv =====
`timescale 1ns / 100ps

module speech_utterance_endpointer_core_tb;
  import seu_pkg::*;

  localparam int STAMP_W = 48;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam int DIR_ROWS = 25;
  localparam int MAX_REPORTS = 10;

  // Opcodes the block leaves unused; they must report state with no intent.
  localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    intent_t              intent;
    logic                 reopened;
    mode_t                mode;
    logic [SEQ_BITS-1:0]  seq;
    logic [STAMP_W-1:0]   ustart;
    logic [STAMP_W-1:0]   ufin;
  } result_t;

  // One event to send; rows with a fixed result carry it in fixed_res.
  typedef struct {
    logic [OP_BITS-1:0]  op;
    logic [STAMP_W-1:0]  stamp;
    logic                has_fixed;
    result_t             fixed_res;
  } vad_event_t;

  localparam result_t NO_CHK = '0;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CAP_BITS-1:0] cfg_wdata;

  seu_in_if #(.STAMP_BITS(STAMP_W)) in_ch ();
  seu_out_if #(.STAMP_BITS(STAMP_W)) out_ch ();

  speech_utterance_endpointer_core #(.STAMP_BITS(STAMP_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Endpointer state as the testbench tracks it.
  logic [CAP_BITS-1:0]  cap_samples;
  mode_t                cur_mode;
  logic                 barge_held;
  logic [STAMP_W-1:0]   utt_start;
  logic [STAMP_W-1:0]   barge_start;
  logic [STAMP_W-1:0]   utt_fin;
  logic [SEQ_BITS-1:0]  utt_count;

  vad_event_t pending_events[$];
  result_t    expected_results[$];

  int n_fail = 0;
  int n_events = 0;
  int n_begin = 0;
  int n_end = 0;
  int n_reopen = 0;
  int stall_request = 0;
  logic [STAMP_W-1:0] gen_clock = '0;

  // Directed events: edge cases first, then a full barge-in cycle and the unused opcodes.
  vad_event_t dir_rows [DIR_ROWS] = '{
    '{OP_END,     48'd0,      1'b1, '{INTENT_NONE, 1'b0, MODE_IDLE, 32'd0, 48'd0, 48'd0}},
    '{OP_TICK,    STAMP_MAX,  1'b1, '{INTENT_NONE, 1'b0, MODE_IDLE, 32'd0, 48'd0, 48'd0}},
    '{OP_FORCE,   48'd12345,  1'b1, '{INTENT_NONE, 1'b0, MODE_IDLE, 32'd0, 48'd0, 48'd0}},
    '{OP_START,   48'd100,    1'b1,
      '{INTENT_BEGIN, 1'b0, MODE_SPEAKING, 32'd1, 48'd100, 48'd0}},
    '{OP_START,   48'd5,      1'b1,
      '{INTENT_NONE, 1'b0, MODE_SPEAKING, 32'd1, 48'd100, 48'd0}},
    '{OP_TICK,    48'd480099, 1'b0, NO_CHK},
    '{OP_TICK,    48'd50,     1'b0, NO_CHK},
    '{OP_TICK,    48'd480100, 1'b0, NO_CHK},
    '{OP_START,   48'd600000, 1'b0, NO_CHK},
    '{OP_START,   48'd700000, 1'b0, NO_CHK},
    '{OP_DONE,    48'd0,      1'b0, NO_CHK},
    '{OP_FORCE,   STAMP_MAX,  1'b1,
      '{INTENT_END, 1'b0, MODE_FINALIZING, 32'd2, 48'd700000, STAMP_MAX}},
    '{OP_START,   48'd5,      1'b0, NO_CHK},
    '{OP_END,     48'd0,      1'b0, NO_CHK},
    '{OP_DONE,    STAMP_MAX,  1'b0, NO_CHK},
    '{OP_DONE,    48'd0,      1'b0, NO_CHK},
    '{OP_SPARE_6, STAMP_MAX,  1'b0, NO_CHK},
    '{OP_SPARE_7, 48'd0,      1'b0, NO_CHK},
    '{OP_START,   STAMP_MAX,  1'b0, NO_CHK},
    '{OP_DONE,    48'd0,      1'b0, NO_CHK},
    '{OP_START,   48'd0,      1'b0, NO_CHK},
    '{OP_END,     STAMP_MAX,  1'b0, NO_CHK},
    '{OP_START,   48'd1234,   1'b0, NO_CHK},
    '{OP_ABORT,   STAMP_MAX,  1'b0, NO_CHK},
    '{OP_DONE,    48'd0,      1'b0, NO_CHK}
  };

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshakes hang; far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("speech_utterance_endpointer_core_tb NOT OK");
    $finish;
  end

  function automatic void open_utterance_model(input logic [STAMP_W-1:0] stamp);
    cur_mode = MODE_SPEAKING;
    utt_start = stamp;
    utt_count = utt_count + 1'b1;
  endfunction

  function automatic void close_utterance_model(input logic [STAMP_W-1:0] stamp);
    cur_mode = MODE_FINALIZING;
    utt_fin = stamp;
  endfunction

  // Applies one event to the tracked state and returns the result it must produce.
  function automatic result_t step_endpointer(input logic [OP_BITS-1:0] op,
                                              input logic [STAMP_W-1:0] stamp);
    result_t r;
    logic [STAMP_W-1:0] span;
    r = '0;
    case (op)
      OP_START: begin
        if (cur_mode == MODE_IDLE) begin
          open_utterance_model(stamp);
          r.intent = INTENT_BEGIN;
        end else if (cur_mode == MODE_FINALIZING) begin
          barge_held = 1'b1;
          barge_start = stamp;
        end
      end
      OP_END: begin
        if (cur_mode == MODE_SPEAKING) begin
          close_utterance_model(stamp);
          r.intent = INTENT_END;
        end else if (cur_mode == MODE_FINALIZING) begin
          barge_held = 1'b0;
        end
      end
      OP_TICK: begin
        if (cur_mode == MODE_SPEAKING) begin
          // A stamp behind the start counts as zero length.
          span = (stamp >= utt_start) ? stamp - utt_start : '0;
          if (span >= {{(STAMP_W-CAP_BITS){1'b0}}, cap_samples}) begin
            close_utterance_model(stamp);
            r.intent = INTENT_END;
          end
        end
      end
      OP_FORCE: begin
        if (cur_mode == MODE_SPEAKING) begin
          close_utterance_model(stamp);
          r.intent = INTENT_END;
        end
      end
      OP_DONE: begin
        if (barge_held) begin
          barge_held = 1'b0;
          open_utterance_model(barge_start);
          r.intent = INTENT_BEGIN;
          r.reopened = 1'b1;
        end else begin
          cur_mode = MODE_IDLE;
        end
      end
      OP_ABORT: begin
        cur_mode = MODE_IDLE;
        barge_held = 1'b0;
      end
      default: ;
    endcase
    r.mode = cur_mode;
    r.seq = utt_count;
    r.ustart = utt_start;
    r.ufin = utt_fin;
    return r;
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return '0;
      1: return STAMP_MAX;
      2: return r[STAMP_W-1:0];
      default: return STAMP_W'($urandom_range(0, 2000000));
    endcase
  endfunction

  // Tick offset from the start stamp, clustered around the length cap; large
  // offsets wrap the stamp behind the start.
  function automatic logic [STAMP_W-1:0] tick_offset();
    logic [STAMP_W-1:0] c;
    c = {{(STAMP_W-CAP_BITS){1'b0}}, cap_samples};
    case ($urandom_range(0, 5))
      0: return c;
      1: return c - 1'b1;
      2: return c + STAMP_W'($urandom_range(1, 1000));
      3: return STAMP_W'($urandom_range(0, 1000));
      4: return STAMP_MAX - STAMP_W'($urandom_range(0, 1000));
      default: return STAMP_W'($urandom);
    endcase
  endfunction

  function automatic void queue_event(input logic [OP_BITS-1:0] op,
                                      input logic [STAMP_W-1:0] stamp);
    vad_event_t ev;
    ev.op = op;
    ev.stamp = stamp;
    ev.has_fixed = 1'b0;
    ev.fixed_res = NO_CHK;
    pending_events.push_back(ev);
  endfunction

  // Queues whole utterances with random content, with some stray events between them.
  task automatic queue_sessions(input int target);
    int made;
    int n;
    int mark;
    logic [STAMP_W-1:0] t0;
    made = 0;
    while (made < target) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_event(OP_BITS'($urandom_range(OP_START, OP_SPARE_7)), rand_stamp());
        made++;
        continue;
      end
      mark = pending_events.size();
      if ($urandom_range(0, 7) == 0) begin
        t0 = rand_stamp();
      end else begin
        gen_clock = gen_clock + STAMP_W'($urandom_range(0, 200000));
        t0 = gen_clock;
      end
      queue_event(OP_START, t0);
      repeat ($urandom_range(0, 3)) queue_event(OP_TICK, t0 + tick_offset());
      case ($urandom_range(0, 3))
        0: queue_event(OP_END, t0 + STAMP_W'($urandom_range(0, 500000)));
        1: queue_event(OP_FORCE, t0 + STAMP_W'($urandom_range(0, 500000)));
        2: queue_event(OP_TICK, t0 + {{(STAMP_W-CAP_BITS){1'b0}}, cap_samples}
                                   + STAMP_W'($urandom_range(0, 3)));
        default: queue_event(OP_TICK, t0 + tick_offset());
      endcase
      // Barge-ins while finalizing, sometimes withdrawn by a speech end.
      n = $urandom_range(0, 2);
      repeat (n) queue_event(OP_START, t0 + STAMP_W'($urandom_range(0, 900000)));
      if (n != 0 && $urandom_range(0, 3) == 0) queue_event(OP_END, rand_stamp());
      queue_event(($urandom_range(0, 4) == 0) ? OP_ABORT : OP_DONE, rand_stamp());
      if (n != 0) begin
        queue_event(OP_END, t0 + STAMP_W'($urandom_range(0, 900000)));
        queue_event(OP_DONE, rand_stamp());
      end
      gen_clock = gen_clock + STAMP_W'($urandom_range(0, 1000000));
      made += pending_events.size() - mark;
    end
  endtask

  // Sends every queued event in bursts with random gaps, predicting each transfer.
  task automatic send_events();
    vad_event_t ev;
    result_t want;
    int burst;
    int gap;
    while (pending_events.size() != 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && pending_events.size() != 0) begin
        ev = pending_events[0];
        pending_events.delete(0);
        in_ch.valid <= 1'b1;
        in_ch.opcode <= ev.op;
        in_ch.sample_stamp <= ev.stamp;
        do @(posedge clk); while (!in_ch.ready);
        want = step_endpointer(ev.op, ev.stamp);
        if (ev.has_fixed) want = ev.fixed_res;
        expected_results.push_back(want);
        n_events++;
        if (want.intent == INTENT_BEGIN) n_begin++;
        if (want.intent == INTENT_END) n_end++;
        if (want.reopened) n_reopen++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0 || pending_events.size() == 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cap(input logic [CAP_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_samples = value;
  endtask

  // Result receiver: changes its ready pattern now and then, and honors a long hold-off.
  initial begin : result_sink
    int style;
    int left;
    int hold;
    int phase_cnt;
    style = 0;
    left = 0;
    hold = 0;
    phase_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        hold = stall_request;
        stall_request = 0;
      end
      phase_cnt++;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= (phase_cnt % 5 != 0);
          default: out_ch.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{intent_t'(out_ch.intent), out_ch.reopened, mode_t'(out_ch.mode),
              out_ch.utterance_seq, out_ch.utterance_start, out_ch.utterance_end};
      if (expected_results.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("%t: result with nothing outstanding: intent %0d mode %0d seq %0d",
                   $realtime, got.intent, got.mode, got.seq);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (got.intent !== want.intent || got.reopened !== want.reopened ||
            got.mode !== want.mode || got.seq !== want.seq ||
            got.ustart !== want.ustart || got.ufin !== want.ufin) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("%t: mismatch, expected intent %0d reopened %0d mode %0d seq %0d",
                     $realtime, want.intent, want.reopened, want.mode, want.seq);
            $display("    start %h end %h; got intent %0d reopened %0d mode %0d seq %0d",
                     want.ustart, want.ufin, got.intent, got.reopened, got.mode, got.seq);
            $display("    start %h end %h", got.ustart, got.ufin);
          end
        end
      end
    end
  end

  // Main sequence: reset, directed events, then random phases at several caps.
  initial begin : run_test
    logic [CAP_BITS-1:0] caps [5];
    int counts [5];
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_START;
    in_ch.sample_stamp <= '0;
    cap_samples = CAP_RESET;
    cur_mode = MODE_IDLE;
    barge_held = 1'b0;
    utt_start = '0;
    barge_start = '0;
    utt_fin = '0;
    utt_count = '0;
    caps = '{32'd0, 32'hFFFF_FFFF, CAP_BITS'($urandom_range(1, 5000)), $urandom, CAP_RESET};
    counts = '{300, 300, 450, 400, 380};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs at the reset cap.
    for (int i = 0; i < DIR_ROWS; i++) pending_events.push_back(dir_rows[i]);
    send_events();
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_cap(caps[p]);
      queue_sessions(counts[p]);
      // Two phases hold the receiver off long enough to back up the input.
      if (p == 2 || p == 4) stall_request = 400;
      send_events();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d events over the reset cap and 5 written caps (zero and all ones included).",
             n_events);
    $display("Intents: %0d begin, %0d end, %0d barge-in reopens; %0d mismatches.",
             n_begin, n_end, n_reopen, n_fail);
    if (n_fail == 0 && expected_results.size() == 0) begin
      $display("speech_utterance_endpointer_core_tb OK");
    end else begin
      $display("speech_utterance_endpointer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
